// File: rtl/core/mexp_pkg.sv
package mexp_pkg;

    localparam int BASE_W = 30;
    localparam int EXP_W  = 63;
    localparam int MUL_W  = 32;

    // Prime modulus and Barrett constant floor(2^60 / P); mu fits in 31 bits.
    localparam logic [BASE_W-1:0] MODULUS = 30'd1000000007;
    localparam logic [63:0] BARRETT_MU_FULL = (64'd1 << 60) / 64'd1000000007;
    localparam logic [MUL_W-1:0] BARRETT_MU = BARRETT_MU_FULL[MUL_W-1:0];

    typedef enum logic [1:0] {
        ME_IDLE,
        ME_SCAN,
        ME_WAIT
    } me_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_MU,
        MM_QP,
        MM_FIX
    } mm_state_t;

    typedef struct packed {
        logic              start;
        logic [BASE_W-1:0] a;
        logic [BASE_W-1:0] b;
    } mm_req_t;

    typedef struct packed {
        logic              done;
        logic [BASE_W-1:0] value;
    } mm_rsp_t;

endpackage

// File: rtl/core/mexp_mulmod.sv
// Modular multiply by Barrett reduction on one shared 32x32 multiplier.
// Start in idle; the result is valid in MM_FIX, after the MM_MU and MM_QP states.
module mexp_mulmod (
    input  logic               aclk,
    input  logic               aresetn,
    input  mexp_pkg::mm_req_t  req,
    output mexp_pkg::mm_rsp_t  rsp
);

    localparam logic [31:0] MOD32  = {2'b00, mexp_pkg::MODULUS};
    localparam logic [31:0] MOD32X2 = {1'b0, mexp_pkg::MODULUS, 1'b0};

    mexp_pkg::mm_state_t state_reg, state_next;

    logic [63:0]                  mult_reg;
    logic [59:0]                  prod_reg;
    logic [mexp_pkg::MUL_W-1:0]   op_a, op_b;
    logic                         mult_en;
    logic [31:0]                  diff, diff_m1, diff_m2;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::MM_IDLE: if (req.start) state_next = mexp_pkg::MM_MU;
            mexp_pkg::MM_MU:   state_next = mexp_pkg::MM_QP;
            mexp_pkg::MM_QP:   state_next = mexp_pkg::MM_FIX;
            mexp_pkg::MM_FIX:  state_next = mexp_pkg::MM_IDLE;
            default:           state_next = mexp_pkg::MM_IDLE;
        endcase
    end

    // Operand select for the shared multiplier.
    always_comb begin
        op_a    = {2'b00, req.a};
        op_b    = {2'b00, req.b};
        mult_en = 1'b0;
        case (state_reg)
            mexp_pkg::MM_IDLE: begin
                mult_en = req.start;
            end
            mexp_pkg::MM_MU: begin
                op_a    = {1'b0, mult_reg[59:29]};
                op_b    = mexp_pkg::BARRETT_MU;
                mult_en = 1'b1;
            end
            mexp_pkg::MM_QP: begin
                op_a    = {1'b0, mult_reg[61:31]};
                op_b    = MOD32;
                mult_en = 1'b1;
            end
            default: begin
                mult_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::MM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mult_en) begin
            mult_reg <= op_a * op_b;
        end
        if (state_reg == mexp_pkg::MM_MU) begin
            prod_reg <= mult_reg[59:0];
        end
    end

    // Barrett quotient is short by at most two, so the remainder is below 3P.
    assign diff    = prod_reg[31:0] - mult_reg[31:0];
    assign diff_m1 = diff - MOD32;
    assign diff_m2 = diff - MOD32X2;

    always_comb begin
        rsp.done = (state_reg == mexp_pkg::MM_FIX);
        if (diff >= MOD32X2) begin
            rsp.value = diff_m2[mexp_pkg::BASE_W-1:0];
        end else if (diff >= MOD32) begin
            rsp.value = diff_m1[mexp_pkg::BASE_W-1:0];
        end else begin
            rsp.value = diff[mexp_pkg::BASE_W-1:0];
        end
    end

endmodule

// File: rtl/core/modular_exponentiation.sv
// Steps: popcount(exponent) plus the index of its top set bit modular multiplies per
//   input beat; none for a zero exponent.
// Throughput: one item at a time; each modular multiply holds the shared 32x32
//   multiplier for three passes.
// Reset: synchronous active-low aresetn clears the sequencer and the output valid.
module modular_exponentiation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // [29:0] base, [92:30] exponent, [95:93] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] power, [31:30] zero
);

    localparam int BW = mexp_pkg::BASE_W;
    localparam int EW = mexp_pkg::EXP_W;

    mexp_pkg::me_state_t state_reg, state_next;

    logic [BW-1:0] x_reg, x_next;
    logic [BW-1:0] acc_reg, acc_next;
    logic [EW-1:0] e_reg, e_next;
    logic          dest_acc_reg, dest_acc_next;   // high: product lands in acc
    logic          m_tvalid_reg, m_tvalid_next;
    logic [BW-1:0] power_reg, power_next;

    logic [BW-1:0] in_base, base_red;
    logic [EW-1:0] in_exp;
    logic          in_beat, out_free;

    mexp_pkg::mm_req_t mm_req;
    mexp_pkg::mm_rsp_t mm_rsp;

    assign in_base  = s_tdata[BW-1:0];
    assign in_exp   = s_tdata[BW+EW-1:BW];
    // A 30-bit base is below 2P, so one subtract brings it into range.
    assign base_red = (in_base >= mexp_pkg::MODULUS) ? in_base - mexp_pkg::MODULUS : in_base;

    assign s_tready = (state_reg == mexp_pkg::ME_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mm_req),
        .rsp     (mm_rsp)
    );

    // Next state: scan the exponent, one multiply per step, finish at zero.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mexp_pkg::ME_IDLE: begin
                if (in_beat) state_next = mexp_pkg::ME_SCAN;
            end
            mexp_pkg::ME_SCAN: begin
                if (e_reg != '0) begin
                    state_next = mexp_pkg::ME_WAIT;
                end else if (out_free) begin
                    state_next = mexp_pkg::ME_IDLE;
                end
            end
            mexp_pkg::ME_WAIT: begin
                if (mm_rsp.done) state_next = mexp_pkg::ME_SCAN;
            end
            default: state_next = mexp_pkg::ME_IDLE;
        endcase
    end

    // Datapath and handshake outputs.
    always_comb begin
        x_next        = x_reg;
        acc_next      = acc_reg;
        e_next        = e_reg;
        dest_acc_next = dest_acc_reg;
        power_next    = power_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mm_req.start  = 1'b0;
        mm_req.a      = acc_reg;
        mm_req.b      = x_reg;
        case (state_reg)
            mexp_pkg::ME_IDLE: begin
                if (in_beat) begin
                    x_next   = base_red;
                    e_next   = in_exp;
                    acc_next = BW'(1);
                end
            end
            mexp_pkg::ME_SCAN: begin
                if (e_reg != '0) begin
                    mm_req.start = 1'b1;
                    if (e_reg[0]) begin
                        // odd: fold base into the answer, drop the low bit
                        mm_req.a      = acc_reg;
                        dest_acc_next = 1'b1;
                        e_next        = {e_reg[EW-1:1], 1'b0};
                    end else begin
                        // even: square the base, halve the exponent
                        mm_req.a      = x_reg;
                        dest_acc_next = 1'b0;
                        e_next        = {1'b0, e_reg[EW-1:1]};
                    end
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    power_next    = acc_reg;
                end
            end
            mexp_pkg::ME_WAIT: begin
                if (mm_rsp.done) begin
                    if (dest_acc_reg) begin
                        acc_next = mm_rsp.value;
                    end else begin
                        x_next = mm_rsp.value;
                    end
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= mexp_pkg::ME_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg        <= x_next;
        acc_reg      <= acc_next;
        e_reg        <= e_next;
        dest_acc_reg <= dest_acc_next;
        power_reg    <= power_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, power_reg};

    // Hold off new input beats for the whole exponentiation.
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    a_power_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:0] < mexp_pkg::MODULUS))
        else $error("result not reduced");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mm_rsp.done |-> (state_reg == mexp_pkg::ME_WAIT))
        else $error("multiply finished outside wait");

endmodule

// File: sim/modular_exponentiation_test.sv
module modular_exponentiation_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BASE_W = mexp_pkg::BASE_W;
    localparam int EXP_W  = mexp_pkg::EXP_W;
    localparam logic [BASE_W-1:0] MODULUS = mexp_pkg::MODULUS;

    // Idle cycles with no beat on either channel before the run is declared hung.
    localparam int HANG_LIMIT   = 4000;
    // Cycles to hold after the last result before the verdict.
    localparam int TAIL_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 1650;
    localparam int NUM_DIRECTED = 24;

    localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
    localparam logic [BASE_W-1:0] BASE_MAX = {BASE_W{1'b1}};
    localparam logic [BASE_W-1:0] MOD_M1   = MODULUS - 30'd1;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
        bit                known;  // power column is typed in, else predicted
        logic [BASE_W-1:0] power;
    } pow_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;   // [29:0] base, [92:30] exponent, [95:93] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [29:0] power, [31:30] zero

    // Powers still owed by the block, oldest first.
    logic [BASE_W-1:0] power_q[$];
    int                mismatch_count;
    // Clear to run a stretch with no gaps on either side.
    bit                idle_on;

    // Directed beats: zero exponent, zero base, the extremes of both fields,
    // bases at and above the modulus, minus one, and a base raised to P-1.
    pow_row_t dir_rows [NUM_DIRECTED] = '{
        '{30'd0,          63'd0,           1'b1, 30'd1},
        '{MOD_M1,         63'd0,           1'b1, 30'd1},
        '{BASE_MAX,       63'd0,           1'b1, 30'd1},
        '{30'd0,          63'd1,           1'b1, 30'd0},
        '{30'd0,          EXP_MAX,         1'b1, 30'd0},
        '{30'd1,          EXP_MAX,         1'b1, 30'd1},
        '{30'd5,          63'd1,           1'b1, 30'd5},
        '{30'd2,          63'd10,          1'b1, 30'd1024},
        '{30'd2,          63'd29,          1'b1, 30'd536870912},
        '{MOD_M1,         63'd1,           1'b1, MOD_M1},
        '{MOD_M1,         63'd2,           1'b1, 30'd1},
        '{MOD_M1,         63'd3,           1'b1, MOD_M1},
        '{MOD_M1,         EXP_MAX,         1'b1, MOD_M1},
        '{MOD_M1,         63'd1 << 62,     1'b1, 30'd1},
        '{MODULUS,        63'd5,           1'b1, 30'd0},
        '{MODULUS + 30'd1, 63'd7,          1'b1, 30'd1},
        '{BASE_MAX,       63'd1,           1'b1, 30'd73741816},
        '{30'd3,          63'd1000000006,  1'b1, 30'd1},
        '{BASE_MAX,       EXP_MAX,         1'b0, 30'd0},
        '{30'd2,          63'd1 << 62,     1'b0, 30'd0},
        '{30'd123456789,  63'd1000000005,  1'b0, 30'd0},
        '{30'd7,          63'h5555_5555_5555_5555, 1'b0, 30'd0},
        '{30'd1 << 29,    63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 30'd0},
        '{30'd999999999,  EXP_MAX - 63'd1, 1'b0, 30'd0}
    };

    modular_exponentiation dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Square-and-multiply modulo the prime: halve an even exponent while
    // squaring, take one from an odd exponent while folding the base in.
    function automatic logic [BASE_W-1:0] mod_pow_p(input logic [BASE_W-1:0] b,
                                                    input logic [EXP_W-1:0] e);
        logic [63:0]      x;
        logic [63:0]      acc;
        logic [EXP_W-1:0] k;
        x   = 64'(b) % 64'(MODULUS);
        acc = 64'd1;
        k   = e;
        while (k != '0) begin
            if (!k[0]) begin
                k = k >> 1;
                x = (x * x) % 64'(MODULUS);
            end else begin
                acc = (acc * x) % 64'(MODULUS);
                k   = k - 1'b1;
            end
        end
        return acc[BASE_W-1:0];
    endfunction

    // Present one beat at a falling edge, hold it until accepted, and queue
    // the power it is owed. Returns at the falling edge after acceptance with
    // tvalid still high, so a zero gap gives back-to-back beats.
    task automatic send_beat(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e,
                             input logic [BASE_W-1:0] owed);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, e, b};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        power_q.push_back(owed);
        @(negedge aclk);
    endtask

    // Random base: mostly the full 30-bit range, with extra weight on the
    // values at and above the modulus and on zero, one and minus one.
    function automatic logic [BASE_W-1:0] pick_base();
        logic [BASE_W-1:0] b;
        case ($urandom_range(0, 9))
            0: b = MODULUS + 30'($urandom_range(0, 73741816));
            1: begin
                case ($urandom_range(0, 2))
                    0: b = 30'd0;
                    1: b = 30'd1;
                    default: b = MOD_M1;
                endcase
            end
            default: b = 30'($urandom);
        endcase
        return b;
    endfunction

    // Random exponent: half full width, the rest narrowed to a random width
    // to keep the run short, plus some powers of two and the maximum.
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] r;
        logic [EXP_W-1:0] e;
        int kind;
        int w;
        r    = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        w    = $urandom_range(0, 62);
        if (kind < 5) begin
            e = r[EXP_W-1:0];
        end else if (kind < 9) begin
            e = r[EXP_W-1:0] & ((63'd1 << w) - 63'd1);
        end else if (r[63]) begin
            e = 63'd1 << w;
        end else begin
            e = EXP_MAX;
        end
        return e;
    endfunction

    // Result side: draw a stall per beat, then hold tready until a beat moves.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Compare every result beat with the oldest owed power; pad bits must be zero.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (power_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual %0d",
                         $time, m_tdata);
            end else if (m_tdata !== {2'b00, power_q[0]}) begin
                mismatch_count++;
                $display("%0t: power mismatch, expected %0d, actual %0d",
                         $time, power_q[0], m_tdata);
                void'(power_q.pop_front());
            end else begin
                void'(power_q.pop_front());
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        logic [BASE_W-1:0] b;
        logic [EXP_W-1:0]  e;
        mismatch_count = 0;
        idle_on        = 1'b1;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed table: typed-in powers where obvious, predicted otherwise.
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].base, dir_rows[i].exponent,
                      dir_rows[i].known ? dir_rows[i].power
                                        : mod_pow_p(dir_rows[i].base, dir_rows[i].exponent));
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // Switch between idling and gap-free stretches now and then.
            if (i % 150 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            // Drop tvalid and drain the block completely before going on.
            if (i % 400 == 200) begin
                s_tvalid = 1'b0;
                wait (power_q.size() == 0);
                @(negedge aclk);
            end
            b = pick_base();
            e = pick_exponent();
            send_beat(b, e, mod_pow_p(b, e));
        end
        s_tvalid = 1'b0;

        // Drain, then hold a while to catch any stray result beat.
        wait (power_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (power_q.size() != 0) begin
            mismatch_count++;
            $display("%0t: %0d results never arrived, expected %0d, actual none",
                     $time, power_q.size(), power_q[0]);
        end

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
